>>> design/gpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gpg_pkg;

   localparam int MAX_DIM = 4096;
   localparam int DIM_W = 13;
   localparam int CNT_W = 12;
   localparam int COLOR_W = 24;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_WIDTH = 3'd1;
   localparam logic [2:0] REG_HEIGHT = 3'd2;
   localparam logic [2:0] REG_START = 3'd3;
   localparam logic [2:0] REG_TARGET = 3'd4;

   localparam logic [1:0] MODE_ROW = 2'd0;
   localparam logic [1:0] MODE_COLUMN = 2'd1;
   localparam logic [1:0] MODE_DIAGONAL = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic [COLOR_W-1:0] start_color;
      logic [COLOR_W-1:0] target_color;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] column;
      logic [CNT_W-1:0] row;
      logic row_end;
      logic [1:0] pad_bytes;
      logic frame_end;
   } entry_type;

   // A zero size counts as one and anything above the maximum as the maximum.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/gradient_pattern_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Raster linear-gradient test pattern generator. Each accepted request word
// yields one response word holding the next pixel of a frame_width by
// frame_height frame in row order, as blue, green and red bytes, with row_end,
// frame_end and the 24-bit BMP row padding count at each row end. Setting
// req_restart restarts the frame at row 0 column 0 for that pixel. The front
// end advances the column and row counters and places the word in a
// four-entry queue, so requests are taken in single cycles until the queue
// fills. The back end computes each channel exactly, one multiply per step,
// with a restoring divider yielding one quotient bit per cycle, and finishes
// a word before it pops the next; a word is quickest for the unused mode or
// saturated channels, slowest with eight divide steps on all three channels.
// Configuration registers are written through csr_we, csr_index and csr_wdata
// only while the block is idle, a rule for the user that it does not enforce.
module gradient_pattern_generator import gpg_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic [2:0] csr_index,
   input wire logic [COLOR_W-1:0] csr_wdata,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic req_restart,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_red,
   output logic rsp_row_end,
   output logic [1:0] rsp_pad_bytes,
   output logic rsp_frame_end
);

   cfg_type cfg_ff;
   logic push, pop, queue_full, queue_empty;
   entry_type push_entry, head;

   // Configuration registers; writes to unused indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= MODE_COLUMN;
         cfg_ff.frame_width <= DIM_W'(512);
         cfg_ff.frame_height <= DIM_W'(512);
         cfg_ff.start_color <= 24'hFFC800;
         cfg_ff.target_color <= 24'h6400FF;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE: cfg_ff.mode <= csr_wdata[1:0];
            REG_WIDTH: cfg_ff.frame_width <= csr_wdata[DIM_W-1:0];
            REG_HEIGHT: cfg_ff.frame_height <= csr_wdata[DIM_W-1:0];
            REG_START: cfg_ff.start_color <= csr_wdata;
            REG_TARGET: cfg_ff.target_color <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   gpg_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_restart(req_restart),
      .queue_full(queue_full),
      .req_ready(req_ready),
      .push(push),
      .push_entry(push_entry)
   );

   gpg_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .pop(pop),
      .full(queue_full),
      .empty(queue_empty),
      .head(head)
   );

   gpg_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .queue_empty(queue_empty),
      .head(head),
      .pop(pop),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_blue(rsp_blue),
      .rsp_green(rsp_green),
      .rsp_red(rsp_red),
      .rsp_row_end(rsp_row_end),
      .rsp_pad_bytes(rsp_pad_bytes),
      .rsp_frame_end(rsp_frame_end)
   );

endmodule
`default_nettype wire

>>> design/gpg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gpg_front import gpg_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire cfg_type cfg,
   input wire logic req_valid,
   input wire logic req_restart,
   input wire logic queue_full,
   output logic req_ready,
   output logic push,
   output entry_type push_entry
);

   logic [CNT_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] x, y;
   logic [DIM_W-1:0] w, h;
   logic [1:0] w3;

   assign req_ready = !queue_full;
   assign push = req_valid && !queue_full;

   always_comb begin
      w = clamp_dim(cfg.frame_width);
      h = clamp_dim(cfg.frame_height);
      x = req_restart ? '0 : column_ff;
      y = req_restart ? '0 : row_ff;
      w3 = 2'(2'(w[1:0]) + 2'({w[1:0], 1'b0}));
      push_entry.column = x;
      push_entry.row = y;
      push_entry.row_end = {1'b0, x} >= (w - DIM_W'(1));
      push_entry.frame_end = push_entry.row_end && ({1'b0, y} >= (h - DIM_W'(1)));
      push_entry.pad_bytes = push_entry.row_end ? 2'(2'd0 - w3) : 2'd0;
      column_in = push_entry.row_end ? '0 : CNT_W'(x + CNT_W'(1));
      row_in = y;
      if (push_entry.row_end) begin
         row_in = push_entry.frame_end ? '0 : CNT_W'(y + CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff <= '0;
      end else if (push) begin
         column_ff <= column_in;
         row_ff <= row_in;
      end
   end

endmodule
`default_nettype wire

>>> design/gpg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module gpg_queue import gpg_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire entry_type push_entry,
   input wire logic pop,
   output logic full,
   output logic empty,
   output entry_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   entry_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0] count_ff;

   assign full = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= PTR_W'(wr_ff + PTR_W'(1));
         end
         if (pop) begin
            rd_ff <= PTR_W'(rd_ff + PTR_W'(1));
         end
         if (push && !pop) begin
            count_ff <= (PTR_W+1)'(count_ff + 1'b1);
         end else if (pop && !push) begin
            count_ff <= (PTR_W+1)'(count_ff - 1'b1);
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue count past depth");
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
`endif

endmodule
`default_nettype wire

>>> design/gpg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module gpg_back import gpg_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire cfg_type cfg,
   input wire logic queue_empty,
   input wire entry_type head,
   output logic pop,
   input wire logic rsp_ready,
   output logic rsp_valid,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_red,
   output logic rsp_row_end,
   output logic [1:0] rsp_pad_bytes,
   output logic rsp_frame_end
);

   typedef enum logic [3:0] {
      B_IDLE, B_HW, B_YW, B_XH, B_SEL, B_MUL1, B_MUL2, B_SUB, B_DIV, B_OUT
   } state_type;

   state_type state_ff;
   entry_type item_ff;
   logic [1:0] ch_ff;
   logic [2:0] bit_ff;
   logic [24:0] hw_ff, yw_ff, xh_ff, den_ff;
   logic [25:0] v_ff;
   logic [32:0] sd_ff, rem_ff;
   logic signed [35:0] dp_ff;
   logic [7:0] q_ff, blue_ff, green_ff, red_ff;
   logic valid_ff;
   // Response register; it holds a word steady while the next one is computed.
   logic [7:0] out_blue_ff, out_green_ff, out_red_ff;
   entry_type out_item_ff;

   logic [DIM_W-1:0] w, h;
   logic [7:0] s, t;
   logic signed [8:0] delta, d2, k;
   logic signed [35:0] n;
   logic [32:0] cmp_in;
   logic [35:0] top_in;

   always_comb begin
      w = clamp_dim(cfg.frame_width);
      h = clamp_dim(cfg.frame_height);
      s = 8'(cfg.start_color >> {ch_ff, 3'b000});
      t = 8'(cfg.target_color >> {ch_ff, 3'b000});
      delta = $signed({1'b0, s}) - $signed({1'b0, t});
      // Arithmetic shift rounds down, so odd negative deltas are bumped first to halve toward zero.
      d2 = (delta + $signed({8'd0, delta[8]})) >>> 1;
      k = (cfg.mode == MODE_DIAGONAL) ? d2 : delta;
      n = $signed({3'b000, sd_ff}) - dp_ff;
      cmp_in = 33'(den_ff) << bit_ff;
      top_in = {3'b000, den_ff, 8'd0};
   end

   assign pop = (state_ff == B_IDLE) && !queue_empty;
   assign rsp_valid = valid_ff;
   assign rsp_blue = out_blue_ff;
   assign rsp_green = out_green_ff;
   assign rsp_red = out_red_ff;
   assign rsp_row_end = out_item_ff.row_end;
   assign rsp_pad_bytes = out_item_ff.pad_bytes;
   assign rsp_frame_end = out_item_ff.frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (valid_ff && rsp_ready && state_ff != B_OUT) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (!queue_empty) begin
                  state_ff <= B_HW;
               end
            end
            B_HW: state_ff <= B_YW;
            B_YW: state_ff <= B_XH;
            B_XH: state_ff <= B_SEL;
            B_SEL: state_ff <= B_MUL1;
            B_MUL1: state_ff <= B_MUL2;
            B_MUL2: state_ff <= B_SUB;
            B_SUB: begin
               if (cfg.mode != MODE_ROW && cfg.mode != MODE_COLUMN
                   && cfg.mode != MODE_DIAGONAL) begin
                  state_ff <= (ch_ff == 2'd2) ? B_OUT : B_MUL1;
               end else if (n < 0 || $unsigned(n) >= top_in) begin
                  state_ff <= (ch_ff == 2'd2) ? B_OUT : B_MUL1;
               end else begin
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               if (bit_ff == 3'd0) begin
                  state_ff <= (ch_ff == 2'd2) ? B_OUT : B_MUL1;
               end
            end
            B_OUT: begin
               if (!valid_ff || rsp_ready) begin
                  valid_ff <= 1'b1;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // Datapath registers; one multiply per step, one quotient bit per divide step.
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               item_ff <= head;
            end
            ch_ff <= 2'd0;
         end
         B_HW: hw_ff <= 25'(h) * 25'(w);
         B_YW: yw_ff <= 25'(item_ff.row) * 25'(w);
         B_XH: xh_ff <= 25'(item_ff.column) * 25'(h);
         B_SEL: begin
            case (cfg.mode)
               MODE_ROW: begin
                  den_ff <= 25'(h);
                  v_ff <= 26'(item_ff.row);
               end
               MODE_DIAGONAL: begin
                  den_ff <= hw_ff;
                  v_ff <= 26'(yw_ff) + 26'(xh_ff);
               end
               default: begin
                  den_ff <= 25'(w);
                  v_ff <= 26'(item_ff.column);
               end
            endcase
         end
         B_MUL1: sd_ff <= 33'(s) * 33'(den_ff);
         B_MUL2: dp_ff <= 36'(k) * 36'($signed({1'b0, v_ff}));
         B_SUB: begin
            q_ff <= 8'd0;
            bit_ff <= 3'd7;
            rem_ff <= n[32:0];
            if (cfg.mode != MODE_ROW && cfg.mode != MODE_COLUMN
                && cfg.mode != MODE_DIAGONAL) begin
               ch_ff <= 2'(ch_ff + 2'd1);
               case (ch_ff)
                  2'd0: blue_ff <= s;
                  2'd1: green_ff <= s;
                  default: red_ff <= s;
               endcase
            end else if (n < 0 || $unsigned(n) >= top_in) begin
               ch_ff <= 2'(ch_ff + 2'd1);
               case (ch_ff)
                  2'd0: blue_ff <= (n < 0) ? 8'd0 : 8'd255;
                  2'd1: green_ff <= (n < 0) ? 8'd0 : 8'd255;
                  default: red_ff <= (n < 0) ? 8'd0 : 8'd255;
               endcase
            end
         end
         B_DIV: begin
            bit_ff <= 3'(bit_ff - 3'd1);
            if (rem_ff >= cmp_in) begin
               rem_ff <= rem_ff - cmp_in;
               q_ff[bit_ff] <= 1'b1;
            end
            if (bit_ff == 3'd0) begin
               ch_ff <= 2'(ch_ff + 2'd1);
               case (ch_ff)
                  2'd0: blue_ff <= {q_ff[7:1], rem_ff >= cmp_in};
                  2'd1: green_ff <= {q_ff[7:1], rem_ff >= cmp_in};
                  default: red_ff <= {q_ff[7:1], rem_ff >= cmp_in};
               endcase
            end
         end
         B_OUT: begin
            if (!valid_ff || rsp_ready) begin
               out_blue_ff <= blue_ff;
               out_green_ff <= green_ff;
               out_red_ff <= red_ff;
               out_item_ff <= item_ff;
            end
         end
         default: begin
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == B_HW) else $error("pop did not start work");
   a_out_channels: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_OUT |-> ch_ff == 2'd3) else $error("word ended early");
   a_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff) == B_OUT) else $error("stray result");
`endif

endmodule
`default_nettype wire

>>> sim/tb_gradient_pattern_generator.sv
`timescale 1ns / 1ps
module tb_gradient_pattern_generator;
   import gpg_pkg::*;

   // Expected pixel word as the block should return it.
   typedef struct {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic row_end;
      logic [1:0] pad_bytes;
      logic frame_end;
   } pixel_type;

   // Scoreboard: holds its own copy of the configuration and the raster
   // counters, predicts each pixel as a request word is accepted, and
   // compares returned words against the oldest prediction.
   class pixel_scoreboard;
      logic [1:0] mode;
      logic [12:0] width_reg;
      logic [12:0] height_reg;
      logic [23:0] start_reg;
      logic [23:0] target_reg;
      int unsigned col;
      int unsigned row;
      pixel_type pending[$];
      int errors;
      int checked;
      int row_ends;
      int frame_ends;

      function void clear();
         mode = MODE_COLUMN;
         width_reg = 13'd512;
         height_reg = 13'd512;
         start_reg = 24'hFFC800;
         target_reg = 24'h6400FF;
         col = 0;
         row = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] val);
         case (idx)
            REG_MODE: mode = val[1:0];
            REG_WIDTH: width_reg = val[12:0];
            REG_HEIGHT: height_reg = val[12:0];
            REG_START: start_reg = val;
            REG_TARGET: target_reg = val;
            default: ;
         endcase
      endfunction

      function longint size_of(logic [12:0] v);
         if (v == 0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      // Floor of n/d for positive d, limited to one byte.
      function logic [7:0] floor_byte(longint n, longint d);
         longint q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q = q - 1;
         if (q < 0) q = 0;
         if (q > 255) q = 255;
         return q[7:0];
      endfunction

      function logic [7:0] shade(int sh, longint x, longint y, longint w, longint h);
         longint s;
         longint t;
         longint dl;
         longint d2;
         s = (start_reg >> sh) & 8'hFF;
         t = (target_reg >> sh) & 8'hFF;
         dl = s - t;
         d2 = dl / 2;
         case (mode)
            MODE_ROW: return floor_byte(s * h - dl * y, h);
            MODE_COLUMN: return floor_byte(s * w - dl * x, w);
            MODE_DIAGONAL: return floor_byte(s * h * w - d2 * (y * w + x * h), h * w);
            default: return s[7:0];
         endcase
      endfunction

      function void note_request(logic restart);
         longint w;
         longint h;
         pixel_type p;
         w = size_of(width_reg);
         h = size_of(height_reg);
         if (restart) begin
            col = 0;
            row = 0;
         end
         p.blue = shade(0, col, row, w, h);
         p.green = shade(8, col, row, w, h);
         p.red = shade(16, col, row, w, h);
         p.row_end = (col >= w - 1);
         p.pad_bytes = 0;
         p.frame_end = 0;
         if (p.row_end) begin
            p.pad_bytes = 2'((4 - ((3 * w) & 3)) & 3);
            p.frame_end = (row >= h - 1);
            col = 0;
            row = p.frame_end ? 0 : row + 1;
         end else begin
            col = col + 1;
         end
         pending.push_back(p);
      endfunction

      function void check_word(pixel_type a);
         pixel_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word b=%h g=%h r=%h", $time, a.blue, a.green, a.red);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.row_end) row_ends++;
         if (a.frame_end) frame_ends++;
         if (a.blue !== e.blue)
            $display("%0t: blue expected %h actual %h", $time, e.blue, a.blue);
         if (a.green !== e.green)
            $display("%0t: green expected %h actual %h", $time, e.green, a.green);
         if (a.red !== e.red)
            $display("%0t: red expected %h actual %h", $time, e.red, a.red);
         if (a.row_end !== e.row_end)
            $display("%0t: row_end expected %b actual %b", $time, e.row_end, a.row_end);
         if (a.pad_bytes !== e.pad_bytes)
            $display("%0t: pad_bytes expected %0d actual %0d", $time, e.pad_bytes,
                     a.pad_bytes);
         if (a.frame_end !== e.frame_end)
            $display("%0t: frame_end expected %b actual %b", $time, e.frame_end,
                     a.frame_end);
         if (a.blue !== e.blue || a.green !== e.green || a.red !== e.red ||
             a.row_end !== e.row_end || a.pad_bytes !== e.pad_bytes ||
             a.frame_end !== e.frame_end)
            errors++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [2:0] csr_index = REG_MODE;
   logic [COLOR_W-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_ready;
   logic req_restart = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [7:0] rsp_blue;
   logic [7:0] rsp_green;
   logic [7:0] rsp_red;
   logic rsp_row_end;
   logic [1:0] rsp_pad_bytes;
   logic rsp_frame_end;

   pixel_scoreboard board = new();
   // Idling is allowed only while this is set; the last part runs at full rate.
   bit allow_idle = 1;
   // When set, the receiver holds off for a long stretch.
   bit hold_rsp = 0;
   int hold_cycles = 0;
   int cycle_count = 0;
   int words_sent = 0;

   gradient_pattern_generator dut (.*);

   always #6 clock = ~clock;

   // Watchdog: fails the run if the cycle count passes its limit, which allows
   // for the slowest words and for stalls on both sides.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: accepts words with random stall bursts and checks each one.
   initial begin : receiver
      int gap;
      pixel_type got;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.blue = rsp_blue;
            got.green = rsp_green;
            got.red = rsp_red;
            got.row_end = rsp_row_end;
            got.pad_bytes = rsp_pad_bytes;
            got.frame_end = rsp_frame_end;
            board.check_word(got);
         end
         if (hold_rsp) begin
            rsp_ready <= 0;
            hold_cycles++;
            if (hold_cycles >= 300) hold_rsp = 0;
         end else if (allow_idle && !reset && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            rsp_ready <= 0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // Writes one register while the block is idle and mirrors it in the board.
   task automatic write_csr(logic [2:0] idx, logic [23:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      board.write_reg(idx, val);
   endtask

   // Offers one request word and waits for it to be taken. An idle burst may
   // come first; valid stays up until acceptance.
   task automatic send_word(logic restart);
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      board.note_request(restart);
      words_sent++;
   endtask

   // Lets the block drain before a register write.
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic configure(logic [1:0] m, logic [12:0] w, logic [12:0] h,
                            logic [23:0] s, logic [23:0] t);
      drain();
      write_csr(REG_MODE, m);
      write_csr(REG_WIDTH, w);
      write_csr(REG_HEIGHT, h);
      write_csr(REG_START, s);
      write_csr(REG_TARGET, t);
   endtask

   task automatic random_frame_run(int count, bit big);
      logic [12:0] w;
      logic [12:0] h;
      if (big) begin
         w = $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF;
         h = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
      end else begin
         w = $urandom_range(0, 9);
         h = $urandom_range(0, 9);
      end
      configure($urandom_range(0, 3), w, h, $urandom_range(0, 24'hFFFFFF),
                $urandom_range(0, 24'hFFFFFF));
      for (int i = 0; i < count; i++)
         send_word($urandom_range(0, 30) == 0);
   endtask

   initial begin : stimulus
      board.clear();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: reset settings, then each mode with extreme colors,
      // a zero size, oversized sizes, the unused mode and a restart.
      send_word(1);
      send_word(0);
      send_word(0);
      configure(MODE_ROW, 13'd3, 13'd2, 24'hFFFFFF, 24'h000000);
      repeat (6) send_word(0);
      configure(MODE_DIAGONAL, 13'd0, 13'd0, 24'h000000, 24'hFFFFFF);
      repeat (2) send_word(0);
      configure(MODE_DIAGONAL, 13'd2, 13'd2, 24'h00FF00, 24'hFF00FF);
      repeat (4) send_word(0);
      configure(2'd3, 13'h1FFF, 13'd4096, 24'hA5A55A, 24'h5A5AA5);
      send_word(0);
      send_word(1);
      // Shrinking the frame in mid row leaves counters past the end.
      configure(MODE_COLUMN, 13'd8, 13'd8, 24'hFF00FF, 24'h00FF00);
      repeat (6) send_word(0);
      configure(MODE_COLUMN, 13'd2, 13'd2, 24'hFF00FF, 24'h00FF00);
      repeat (3) send_word(0);

      // Long receiver hold while requests keep coming, to fill the queue.
      hold_cycles = 0;
      hold_rsp = 1;
      repeat (12) send_word(0);

      // Random part: mostly small frames, a few at the largest size.
      for (int k = 0; k < 40; k++)
         random_frame_run($urandom_range(20, 50), k % 10 == 9);
      allow_idle = 0;
      random_frame_run(100, 0);
      random_frame_run(100, 0);

      drain();
      $display("Sent %0d words and checked %0d, with %0d row ends and %0d frame ends,",
               words_sent, board.checked, board.row_ends, board.frame_ends);
      $display("over all modes, sizes from zero to oversized, restarts and stalls.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

>>> filelist.f
design/gpg_pkg.sv
design/gpg_front.sv
design/gpg_queue.sv
design/gpg_back.sv
design/gradient_pattern_generator.sv
sim/tb_gradient_pattern_generator.sv
